>>> design/sdsi_pkg.sv
// Shared types, codes and command frame table for the SD SPI start-up sequencer.
// No dependencies; used by every module in design/.
package sdsi_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLL_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_WAKE_BYTES  = 2'd2;

    // Register reset values
    localparam logic [7:0]  POLL_LIMIT_RST  = 8'd20;
    localparam logic [15:0] RETRY_LIMIT_RST = 16'd10000;
    localparam logic [7:0]  WAKE_BYTES_RST  = 8'd10;

    // Chip-select requests
    localparam logic [1:0] CS_NONE  = 2'd0;
    localparam logic [1:0] CS_CLEAR = 2'd1;
    localparam logic [1:0] CS_SET   = 2'd2;

    // Final status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CMD0_FAIL  = 3'd1;
    localparam logic [2:0] ST_CMD8_FAIL  = 3'd2;
    localparam logic [2:0] ST_VOLT_FAIL  = 3'd3;
    localparam logic [2:0] ST_ACMD41_TMO = 3'd4;
    localparam logic [2:0] ST_CMD16_FAIL = 3'd5;

    // Input functions
    localparam logic FUNC_START = 1'b0;

    // Byte values
    localparam logic [7:0] IDLE_BYTE     = 8'hFF;
    localparam logic [7:0] R1_IN_IDLE    = 8'h01;
    localparam logic [7:0] R1_READY      = 8'h00;
    localparam logic [7:0] CHECK_PATTERN = 8'hAA;
    localparam logic [7:0] CMD_START     = 8'h40;

    // Last frame byte index (CRC); one past it starts polling
    localparam logic [2:0] FRAME_LAST = 3'd6;
    // Index of the R7 trailer byte that must hold the check pattern
    localparam logic [2:0] R7_LAST    = 3'd4;

    // Command slots
    typedef enum logic [2:0] {
        SLOT_CMD0,
        SLOT_CMD8,
        SLOT_CMD55,
        SLOT_ACMD41,
        SLOT_CMD16
    } slot_t;

    typedef struct packed {
        logic [7:0]  poll_limit;
        logic [15:0] retry_limit;
        logic [7:0]  wake_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic [1:0] cs_request;
        logic       slow_clock;
        logic       done_res;
        logic [2:0] status;
    } res_t;

    // Byte idx of a command frame: 0xFF, cmd|0x40, arg MSB first, CRC
    function automatic logic [7:0] frame_byte(slot_t slot, logic [2:0] idx);
        logic [7:0]  code;
        logic [31:0] arg;
        logic [7:0]  crc;
        logic [7:0]  b;
        case (slot)
            SLOT_CMD0: begin
                code = 8'd0;  arg = 32'h0000_0000; crc = 8'h95;
            end
            SLOT_CMD8: begin
                code = 8'd8;  arg = 32'h0000_01AA; crc = 8'h87;
            end
            SLOT_CMD55: begin
                code = 8'd55; arg = 32'h0000_0000; crc = 8'h65;
            end
            SLOT_ACMD41: begin
                code = 8'd41; arg = 32'h4000_0000; crc = 8'h77;
            end
            default: begin
                code = 8'd16; arg = 32'd512;       crc = 8'h15;
            end
        endcase
        case (idx)
            3'd0:    b = IDLE_BYTE;
            3'd1:    b = code | CMD_START;
            3'd2:    b = arg[31:24];
            3'd3:    b = arg[23:16];
            3'd4:    b = arg[15:8];
            3'd5:    b = arg[7:0];
            default: b = crc;
        endcase
        return b;
    endfunction

endpackage

>>> design/sdsi_cfg_regs.sv
// Configuration registers of the SD SPI start-up sequencer.
// Depends on sdsi_pkg (register indexes, reset values, cfg_t).
module sdsi_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_wdata,
    output sdsi_pkg::cfg_t      cfg
);

    sdsi_pkg::cfg_t cfg_reg;

    // Register file; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.poll_limit  <= sdsi_pkg::POLL_LIMIT_RST;
            cfg_reg.retry_limit <= sdsi_pkg::RETRY_LIMIT_RST;
            cfg_reg.wake_bytes  <= sdsi_pkg::WAKE_BYTES_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                sdsi_pkg::CFG_POLL_LIMIT:  cfg_reg.poll_limit  <= cfg_wdata[7:0];
                sdsi_pkg::CFG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_wdata;
                sdsi_pkg::CFG_WAKE_BYTES:  cfg_reg.wake_bytes  <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/sdsi_core.sv
// Sequencer state and next-byte logic: one registered item in, one result out.
// Depends on sdsi_pkg (cfg_t, res_t, codes, frame_byte).
module sdsi_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                proc,      // item in the input register is consumed
    input  logic                func,
    input  logic [7:0]          rx_byte,
    input  sdsi_pkg::cfg_t      cfg,
    output sdsi_pkg::res_t      res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_WAKE,
        PH_C0F,  PH_C0P,
        PH_C8F,  PH_C8P,
        PH_R7,
        PH_C55F, PH_C55P,
        PH_A41F, PH_A41P,
        PH_C16F, PH_C16P
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  frame_index_reg, frame_index_next;
    logic [7:0]  poll_count_reg, poll_count_next;
    logic [15:0] retry_count_reg, retry_count_next;
    logic [7:0]  wake_count_reg, wake_count_next;
    logic        clock_slow_reg, clock_slow_next;

    logic [2:0]  fidx_inc;
    logic [7:0]  poll_inc;
    logic [7:0]  wake_inc;
    logic [15:0] retry_inc;
    logic [7:0]  tx;
    logic        tv;
    logic [1:0]  cs;
    logic        dn;
    logic [2:0]  st;

    function automatic sdsi_pkg::slot_t slot_of(phase_t ph);
        sdsi_pkg::slot_t s;
        case (ph)
            PH_C0F, PH_C0P:   s = sdsi_pkg::SLOT_CMD0;
            PH_C8F, PH_C8P:   s = sdsi_pkg::SLOT_CMD8;
            PH_C55F, PH_C55P: s = sdsi_pkg::SLOT_CMD55;
            PH_A41F, PH_A41P: s = sdsi_pkg::SLOT_ACMD41;
            default:          s = sdsi_pkg::SLOT_CMD16;
        endcase
        return s;
    endfunction

    // Frame phase to its response poll phase
    function automatic phase_t poll_of(phase_t ph);
        phase_t p;
        case (ph)
            PH_C0F:  p = PH_C0P;
            PH_C8F:  p = PH_C8P;
            PH_C55F: p = PH_C55P;
            PH_A41F: p = PH_A41P;
            default: p = PH_C16P;
        endcase
        return p;
    endfunction

    assign fidx_inc  = frame_index_reg + 3'd1;
    assign poll_inc  = poll_count_reg + 8'd1;
    assign wake_inc  = wake_count_reg + 8'd1;
    assign retry_inc = retry_count_reg + 16'd1;

    // Next state and result for the current item
    always_comb begin
        phase_next       = phase_reg;
        frame_index_next = frame_index_reg;
        poll_count_next  = poll_count_reg;
        retry_count_next = retry_count_reg;
        wake_count_next  = wake_count_reg;
        clock_slow_next  = clock_slow_reg;
        tx = sdsi_pkg::IDLE_BYTE;
        tv = 1'b1;
        cs = sdsi_pkg::CS_NONE;
        dn = 1'b0;
        st = sdsi_pkg::ST_OK;

        if (func == sdsi_pkg::FUNC_START) begin
            // Start (or restart) a run
            frame_index_next = '0;
            poll_count_next  = '0;
            retry_count_next = '0;
            wake_count_next  = '0;
            clock_slow_next  = 1'b1;
            phase_next       = PH_WAKE;
            cs               = sdsi_pkg::CS_CLEAR;
        end else begin
            case (phase_reg)
                PH_WAKE: begin
                    wake_count_next = wake_inc;
                    if (wake_inc >= cfg.wake_bytes) begin
                        phase_next       = PH_C0F;
                        frame_index_next = '0;
                        cs               = sdsi_pkg::CS_SET;
                    end
                end
                PH_C0F, PH_C8F, PH_C55F, PH_A41F, PH_C16F: begin
                    frame_index_next = fidx_inc;
                    if (fidx_inc <= sdsi_pkg::FRAME_LAST) begin
                        tx = sdsi_pkg::frame_byte(slot_of(phase_reg), fidx_inc);
                    end else begin
                        phase_next      = poll_of(phase_reg);
                        poll_count_next = '0;
                    end
                end
                PH_C0P, PH_C8P, PH_C55P, PH_A41P, PH_C16P: begin
                    poll_count_next = poll_inc;
                    if (!(rx_byte[7] && (poll_inc < cfg.poll_limit))) begin
                        // Response settled: act on it
                        frame_index_next = '0;
                        case (phase_reg)
                            PH_C0P: begin
                                if (rx_byte != sdsi_pkg::R1_IN_IDLE) begin
                                    dn = 1'b1; st = sdsi_pkg::ST_CMD0_FAIL;
                                end else begin
                                    phase_next = PH_C8F;
                                end
                            end
                            PH_C8P: begin
                                if (rx_byte != sdsi_pkg::R1_IN_IDLE) begin
                                    dn = 1'b1; st = sdsi_pkg::ST_CMD8_FAIL;
                                end else begin
                                    phase_next = PH_R7;
                                end
                            end
                            PH_C55P: begin
                                phase_next = PH_A41F;
                            end
                            PH_A41P: begin
                                if (rx_byte != sdsi_pkg::R1_IN_IDLE) begin
                                    clock_slow_next = 1'b0;
                                    phase_next      = PH_C16F;
                                end else begin
                                    retry_count_next = retry_inc;
                                    if (retry_inc >= cfg.retry_limit) begin
                                        dn = 1'b1; st = sdsi_pkg::ST_ACMD41_TMO;
                                    end else begin
                                        phase_next = PH_C55F;
                                    end
                                end
                            end
                            default: begin
                                dn = 1'b1;
                                st = (rx_byte == sdsi_pkg::R1_READY) ?
                                     sdsi_pkg::ST_OK : sdsi_pkg::ST_CMD16_FAIL;
                            end
                        endcase
                        if (dn) begin
                            frame_index_next = frame_index_reg;
                        end
                    end
                end
                PH_R7: begin
                    frame_index_next = fidx_inc;
                    if (fidx_inc >= sdsi_pkg::R7_LAST) begin
                        if (rx_byte != sdsi_pkg::CHECK_PATTERN) begin
                            dn = 1'b1; st = sdsi_pkg::ST_VOLT_FAIL;
                        end else begin
                            retry_count_next = '0;
                            phase_next       = PH_C55F;
                            frame_index_next = '0;
                        end
                    end
                end
                default: begin
                    // Byte while idle
                    phase_next = PH_IDLE;
                    tv         = 1'b0;
                end
            endcase
        end

        // Run finished: no byte, chip select set only on success
        if (dn) begin
            phase_next = PH_IDLE;
            tv         = 1'b0;
            cs         = (st == sdsi_pkg::ST_OK) ? sdsi_pkg::CS_SET : sdsi_pkg::CS_NONE;
        end

        res.tx_byte    = tv ? tx : 8'd0;
        res.tx_valid   = tv;
        res.cs_request = cs;
        res.slow_clock = clock_slow_next;
        res.done_res   = dn;
        res.status     = dn ? st : sdsi_pkg::ST_OK;
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            frame_index_reg <= '0;
            poll_count_reg  <= '0;
            retry_count_reg <= '0;
            wake_count_reg  <= '0;
            clock_slow_reg  <= 1'b0;
        end else if (proc) begin
            phase_reg       <= phase_next;
            frame_index_reg <= frame_index_next;
            poll_count_reg  <= poll_count_next;
            retry_count_reg <= retry_count_next;
            wake_count_reg  <= wake_count_next;
            clock_slow_reg  <= clock_slow_next;
        end
    end

    // A finished run always returns to idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && res.done_res |=> phase_reg == PH_IDLE)
        else $error("run finished but sequencer not idle");

    // Slow clock is switched on only by a start item
    a_slow_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !clock_slow_reg && clock_slow_next |-> func == sdsi_pkg::FUNC_START)
        else $error("slow clock set outside a start");

    // A start always resets the run counters
    a_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && func == sdsi_pkg::FUNC_START |=>
        phase_reg == PH_WAKE && wake_count_reg == 8'd0 && retry_count_reg == 16'd0)
        else $error("start did not reset run state");

endmodule

>>> design/sd_spi_init_sequencer.sv
// Top level of the SD card SPI-mode start-up sequencer: input and result registers.
// Depends on sdsi_pkg, sdsi_cfg_regs and sdsi_core.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_func, s_rx_byte
//   m_        out        m_valid/m_ready    m_tx_byte, m_tx_valid, m_cs_request,
//                                           m_slow_clock, m_done_res, m_status
//   cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One item per cycle sustained while m_ready is high; each result passes through
// the input register, then the result register fed by the single-pass state logic.
// Reset (aresetn low, synchronous) empties both registers, restores register
// defaults and returns the sequencer to idle with the fast clock flag.
// A stalled result holds the result register; the input register still fills,
// so s_ready drops only when both registers are occupied and m_ready is low.
module sd_spi_init_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_tx_valid,
    output logic [1:0]  m_cs_request,
    output logic        m_slow_clock,
    output logic        m_done_res,
    output logic [2:0]  m_status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    sdsi_pkg::cfg_t cfg;
    sdsi_pkg::res_t res;

    logic       in_valid_reg;
    logic       in_func_reg;
    logic [7:0] in_rx_reg;
    logic       out_valid_reg;
    sdsi_pkg::res_t out_res_reg;
    logic       advance;

    sdsi_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sdsi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .proc    (advance),
        .func    (in_func_reg),
        .rx_byte (in_rx_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Move the held item into the result register when that register frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg <= s_func;
            in_rx_reg   <= s_rx_byte;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_tx_byte    = out_res_reg.tx_byte;
    assign m_tx_valid   = out_res_reg.tx_valid;
    assign m_cs_request = out_res_reg.cs_request;
    assign m_slow_clock = out_res_reg.slow_clock;
    assign m_done_res   = out_res_reg.done_res;
    assign m_status     = out_res_reg.status;

    // A final status never comes with a byte to send
    a_done_no_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_done_res && m_tx_valid))
        else $error("done result carries a byte");

    // Status and byte are zero unless meaningful
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_done_res || m_status == sdsi_pkg::ST_OK) &&
                    (m_tx_valid || m_tx_byte == 8'd0))
        else $error("unused result field not zero");

    // An unaccepted result stays in the result register
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && !$past(advance))
        else $error("result register overwritten under stall");

endmodule

>>> verif/sdsi_checker.sv
`timescale 1ns / 100ps
// Scoreboard for sd_spi_init_sequencer: tracks register writes and input transfers,
// predicts the next SPI step for each one and compares every result transfer.
// Depends on sdsi_pkg.
module sdsi_checker
    import sdsi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_rx_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_tx_byte,
    input  logic        m_tx_valid,
    input  logic [1:0]  m_cs_request,
    input  logic        m_slow_clock,
    input  logic        m_done_res,
    input  logic [2:0]  m_status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          runs_ok,
    output int          runs_err
);

    // Start-up progress; each _TX phase is directly followed by its _POLL phase
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_WAKE,
        SEQ_CMD0_TX,
        SEQ_CMD0_POLL,
        SEQ_CMD8_TX,
        SEQ_CMD8_POLL,
        SEQ_R7,
        SEQ_CMD55_TX,
        SEQ_CMD55_POLL,
        SEQ_ACMD41_TX,
        SEQ_ACMD41_POLL,
        SEQ_CMD16_TX,
        SEQ_CMD16_POLL
    } seq_phase_t;

    seq_phase_t  seq_ph;
    logic [2:0]  byte_idx;
    logic [7:0]  poll_cnt;
    logic [15:0] retry_cnt;
    logic [7:0]  wake_cnt;
    logic        slow_clk;
    cfg_t        regs;

    res_t        step_q[$];
    res_t        got;
    res_t        want;
    res_t        fresh;

    // Whole 7-byte command frame, byte idx picked from the top
    function automatic logic [7:0] cmd_byte(slot_t slot, logic [2:0] idx);
        logic [55:0] frame;
        case (slot)
            SLOT_CMD0:   frame = {8'hFF, 8'h40, 32'h0000_0000, 8'h95};
            SLOT_CMD8:   frame = {8'hFF, 8'h48, 32'h0000_01AA, 8'h87};
            SLOT_CMD55:  frame = {8'hFF, 8'h77, 32'h0000_0000, 8'h65};
            SLOT_ACMD41: frame = {8'hFF, 8'h69, 32'h4000_0000, 8'h77};
            default:     frame = {8'hFF, 8'h50, 32'h0000_0200, 8'h15};
        endcase
        return frame[55 - 8 * int'(idx) -: 8];
    endfunction

    function automatic slot_t slot_for(seq_phase_t ph);
        case (ph)
            SEQ_CMD0_TX:   return SLOT_CMD0;
            SEQ_CMD8_TX:   return SLOT_CMD8;
            SEQ_CMD55_TX:  return SLOT_CMD55;
            SEQ_ACMD41_TX: return SLOT_ACMD41;
            default:       return SLOT_CMD16;
        endcase
    endfunction

    function automatic res_t send_byte(logic [7:0] tx, logic [1:0] cs);
        res_t r;
        r.tx_byte    = tx;
        r.tx_valid   = 1'b1;
        r.cs_request = cs;
        r.slow_clock = slow_clk;
        r.done_res   = 1'b0;
        r.status     = ST_OK;
        return r;
    endfunction

    task automatic open_frame(input seq_phase_t next, input logic [1:0] cs, output res_t r);
        seq_ph   = next;
        byte_idx = 3'd0;
        r        = send_byte(IDLE_BYTE, cs);
    endtask

    // Run over: no byte, chip select set only on success, clock flag left alone
    task automatic close_run(input logic [2:0] st, output res_t r);
        seq_ph       = SEQ_IDLE;
        r.tx_byte    = 8'h00;
        r.tx_valid   = 1'b0;
        r.cs_request = (st == ST_OK) ? CS_SET : CS_NONE;
        r.slow_clock = slow_clk;
        r.done_res   = 1'b1;
        r.status     = st;
    endtask

    // Act on the response byte that ended a poll
    task automatic take_response(input logic [7:0] r1, output res_t r);
        case (seq_ph)
            SEQ_CMD0_POLL: begin
                if (r1 != R1_IN_IDLE) close_run(ST_CMD0_FAIL, r);
                else open_frame(SEQ_CMD8_TX, CS_NONE, r);
            end
            SEQ_CMD8_POLL: begin
                if (r1 != R1_IN_IDLE) begin
                    close_run(ST_CMD8_FAIL, r);
                end else begin
                    seq_ph   = SEQ_R7;
                    byte_idx = 3'd0;
                    r        = send_byte(IDLE_BYTE, CS_NONE);
                end
            end
            SEQ_CMD55_POLL: open_frame(SEQ_ACMD41_TX, CS_NONE, r);
            SEQ_ACMD41_POLL: begin
                if (r1 != R1_IN_IDLE) begin
                    slow_clk = 1'b0;
                    open_frame(SEQ_CMD16_TX, CS_NONE, r);
                end else begin
                    retry_cnt = retry_cnt + 16'd1;
                    if (retry_cnt >= regs.retry_limit) close_run(ST_ACMD41_TMO, r);
                    else open_frame(SEQ_CMD55_TX, CS_NONE, r);
                end
            end
            default: close_run((r1 == R1_READY) ? ST_OK : ST_CMD16_FAIL, r);
        endcase
    endtask

    // One input transfer in, one predicted result out
    task automatic step_sequence(input logic func, input logic [7:0] rx, output res_t r);
        if (func == FUNC_START) begin
            byte_idx  = 3'd0;
            poll_cnt  = 8'd0;
            retry_cnt = 16'd0;
            wake_cnt  = 8'd0;
            slow_clk  = 1'b1;
            seq_ph    = SEQ_WAKE;
            r         = send_byte(IDLE_BYTE, CS_CLEAR);
        end else begin
            case (seq_ph)
                SEQ_WAKE: begin
                    wake_cnt = wake_cnt + 8'd1;
                    if (wake_cnt >= regs.wake_bytes) open_frame(SEQ_CMD0_TX, CS_SET, r);
                    else r = send_byte(IDLE_BYTE, CS_NONE);
                end
                SEQ_CMD0_TX, SEQ_CMD8_TX, SEQ_CMD55_TX, SEQ_ACMD41_TX, SEQ_CMD16_TX: begin
                    byte_idx = byte_idx + 3'd1;
                    if (byte_idx <= FRAME_LAST) begin
                        r = send_byte(cmd_byte(slot_for(seq_ph), byte_idx), CS_NONE);
                    end else begin
                        seq_ph   = seq_phase_t'(seq_ph + 4'd1);
                        poll_cnt = 8'd0;
                        r        = send_byte(IDLE_BYTE, CS_NONE);
                    end
                end
                SEQ_CMD0_POLL, SEQ_CMD8_POLL, SEQ_CMD55_POLL, SEQ_ACMD41_POLL,
                SEQ_CMD16_POLL: begin
                    poll_cnt = poll_cnt + 8'd1;
                    if (rx[7] && poll_cnt < regs.poll_limit) r = send_byte(IDLE_BYTE, CS_NONE);
                    else take_response(rx, r);
                end
                SEQ_R7: begin
                    byte_idx = byte_idx + 3'd1;
                    if (byte_idx < R7_LAST) begin
                        r = send_byte(IDLE_BYTE, CS_NONE);
                    end else if (rx != CHECK_PATTERN) begin
                        close_run(ST_VOLT_FAIL, r);
                    end else begin
                        retry_cnt = 16'd0;
                        open_frame(SEQ_CMD55_TX, CS_NONE, r);
                    end
                end
                default: begin
                    // received byte with no run active: nothing moves
                    seq_ph       = SEQ_IDLE;
                    r            = '0;
                    r.slow_clock = slow_clk;
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Watch all three ports on each rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.poll_limit  = POLL_LIMIT_RST;
            regs.retry_limit = RETRY_LIMIT_RST;
            regs.wake_bytes  = WAKE_BYTES_RST;
            seq_ph    = SEQ_IDLE;
            byte_idx  = 3'd0;
            poll_cnt  = 8'd0;
            retry_cnt = 16'd0;
            wake_cnt  = 8'd0;
            slow_clk  = 1'b0;
            step_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_POLL_LIMIT:  regs.poll_limit  = cfg_wdata[7:0];
                    CFG_RETRY_LIMIT: regs.retry_limit = cfg_wdata;
                    CFG_WAKE_BYTES:  regs.wake_bytes  = cfg_wdata[7:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                got.tx_byte    = m_tx_byte;
                got.tx_valid   = m_tx_valid;
                got.cs_request = m_cs_request;
                got.slow_clock = m_slow_clock;
                got.done_res   = m_done_res;
                got.status     = m_status;
                if (step_q.size() == 0) begin
                    $error("result transfer with no prediction outstanding");
                    fail_count++;
                end else begin
                    want = step_q.pop_front();
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("cs_request", want.cs_request, got.cs_request);
                    check_field("slow_clock", want.slow_clock, got.slow_clock);
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("status", want.status, got.status);
                    checked++;
                    if (want.done_res) begin
                        if (want.status == ST_OK) runs_ok++;
                        else runs_err++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                step_sequence(s_func, s_rx_byte, fresh);
                step_q.push_back(fresh);
            end
        end
        pending <= step_q.size();
    end

endmodule

>>> verif/sd_spi_init_sequencer_test.sv
`timescale 1ns / 100ps
// Stimulus and verdict for sd_spi_init_sequencer: card-side byte scripts for full and
// faulty start-up runs under several register settings, checked by sdsi_checker.
// Depends on sdsi_pkg, sdsi_checker and the design under design/.
module sd_spi_init_sequencer_test;
    import sdsi_pkg::*;

    localparam logic       FUNC_RXBYTE = 1'b1;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    localparam int ITEMS       = 1750;
    localparam int PHASE_ITEMS = 220;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 250;
    localparam int QUIET_LO    = 900;
    localparam int QUIET_HI    = 1300;
    localparam int DRAIN_MAX   = 5000;
    localparam int SETTLE      = 6;

    // Card behavior chosen for one start-up run
    typedef enum logic [2:0] {
        RUN_GOOD,
        RUN_CMD0_BAD,
        RUN_CMD8_BAD,
        RUN_VOLT_BAD,
        RUN_ACMD41_TMO,
        RUN_CMD16_BAD,
        RUN_ABORT,
        RUN_POLL_OUT
    } run_kind_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx;
    } card_item_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_tx_byte;
    logic        m_tx_valid;
    logic [1:0]  m_cs_request;
    logic        m_slow_clock;
    logic        m_done_res;
    logic [2:0]  m_status;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    int fail_count;
    int pending;
    int checked;
    int runs_ok;
    int runs_err;

    int  n_accepted = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    card_item_t  card_q[$];
    logic [7:0]  cur_poll;
    logic [15:0] cur_retry;
    logic [7:0]  cur_wake;
    int          script_items;
    int          n_settings;
    bit          drained;

    sd_spi_init_sequencer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_byte    (m_tx_byte),
        .m_tx_valid   (m_tx_valid),
        .m_cs_request (m_cs_request),
        .m_slow_clock (m_slow_clock),
        .m_done_res   (m_done_res),
        .m_status     (m_status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    sdsi_checker scoreboard (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_tx_byte    (m_tx_byte),
        .m_tx_valid   (m_tx_valid),
        .m_cs_request (m_cs_request),
        .m_slow_clock (m_slow_clock),
        .m_done_res   (m_done_res),
        .m_status     (m_status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .runs_ok      (runs_ok),
        .runs_err     (runs_err)
    );

    always #10 aclk = ~aclk;

    // Hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("sd_spi_init_sequencer regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (s_valid && s_ready) n_accepted <= n_accepted + 1;
    end

    function automatic bit in_quiet();
        return n_accepted >= QUIET_LO && n_accepted < QUIET_HI;
    endfunction

    // Result side: random stalls, one long hold-off, one stall-free window
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= HOLD_AT) begin
            m_ready   <= 1'b0;
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
        end else if (in_quiet()) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 10);
        end
    end

    // One input transfer; s_ready is stable from the falling edge to the next rise
    task automatic send_item(input logic func, input logic [7:0] rx);
        bit taken;
        while (!in_quiet() && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= func;
        s_rx_byte <= rx;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end
    endtask

    task automatic play_script();
        foreach (card_q[i]) send_item(card_q[i].func, card_q[i].rx);
        card_q.delete();
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline settle
    task automatic wait_idle(output bit ok);
        int n;
        s_valid <= 1'b0;
        n = 0;
        @(posedge aclk);
        while (pending != 0 && n < DRAIN_MAX) begin
            @(posedge aclk);
            n++;
        end
        ok = (pending == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Upper data bits of the byte-wide registers are don't-care
    task automatic write_config(input logic [7:0] poll, input logic [15:0] retry,
                                input logic [7:0] wake, input bit spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_POLL_LIMIT;
        cfg_wdata <= {8'($urandom_range(0, 255)), poll};
        @(posedge aclk);
        cfg_index <= CFG_RETRY_LIMIT;
        cfg_wdata <= retry;
        @(posedge aclk);
        cfg_index <= CFG_WAKE_BYTES;
        cfg_wdata <= {8'($urandom_range(0, 255)), wake};
        @(posedge aclk);
        if (spare) begin
            cfg_index <= CFG_SPARE;
            cfg_wdata <= 16'($urandom_range(0, 65535));
            @(posedge aclk);
        end
        cfg_we    <= 1'b0;
        cur_poll  = poll;
        cur_retry = retry;
        cur_wake  = wake;
        n_settings++;
    endtask

    function automatic void push(input logic func, input logic [7:0] rx);
        card_item_t it;
        it.func = func;
        it.rx   = rx;
        card_q.push_back(it);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Any R1 with the busy bit clear except v
    function automatic logic [7:0] r1_other_than(input logic [7:0] v);
        logic [7:0] x;
        do x = 8'($urandom_range(0, 127)); while (x == v);
        return x;
    endfunction

    // Frame bytes: what comes back while the command goes out does not matter
    function automatic void add_frame();
        repeat (7) push(FUNC_RXBYTE, rand_byte());
    endfunction

    // Busy bytes then the response; returns 1 when the card stays busy to the limit
    function automatic bit add_reply(input logic [7:0] resp, input bit run_out);
        int nb;
        if (run_out) begin
            repeat (cur_poll) push(FUNC_RXBYTE, 8'h80 | 8'($urandom_range(0, 127)));
            return 1'b1;
        end
        nb = $urandom_range(0, (cur_poll > 8'd4) ? 3 : int'(cur_poll) - 1);
        repeat (nb) push(FUNC_RXBYTE, 8'h80 | 8'($urandom_range(0, 127)));
        push(FUNC_RXBYTE, resp);
        return 1'b0;
    endfunction

    function automatic run_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return RUN_GOOD;
        if (r < 57) return RUN_CMD0_BAD;
        if (r < 64) return RUN_CMD8_BAD;
        if (r < 71) return RUN_VOLT_BAD;
        if (r < 78) return RUN_ACMD41_TMO;
        if (r < 85) return RUN_CMD16_BAD;
        if (r < 93) return RUN_ABORT;
        return RUN_POLL_OUT;
    endfunction

    // Card-side bytes for one start-up run
    function automatic void build_run(input run_kind_t kind);
        int         poll_at;
        int         tries;
        logic [7:0] r1;
        poll_at = (kind == RUN_POLL_OUT) ? $urandom_range(0, 4) : -1;
        if (kind == RUN_ACMD41_TMO && cur_retry > 16'd8) kind = RUN_GOOD;

        push(FUNC_START, rand_byte());
        repeat (cur_wake) push(FUNC_RXBYTE, rand_byte());

        // CMD0
        add_frame();
        r1 = (kind == RUN_CMD0_BAD) ? r1_other_than(R1_IN_IDLE) : R1_IN_IDLE;
        if (add_reply(r1, poll_at == 0) || kind == RUN_CMD0_BAD) return;

        // CMD8 and its R7 trailer
        add_frame();
        r1 = (kind == RUN_CMD8_BAD) ? r1_other_than(R1_IN_IDLE) : R1_IN_IDLE;
        if (add_reply(r1, poll_at == 1) || kind == RUN_CMD8_BAD) return;
        repeat (3) push(FUNC_RXBYTE, rand_byte());
        if (kind == RUN_VOLT_BAD) begin
            do r1 = rand_byte(); while (r1 == CHECK_PATTERN);
            push(FUNC_RXBYTE, r1);
            return;
        end
        push(FUNC_RXBYTE, CHECK_PATTERN);

        // CMD55/ACMD41 pairs while the card still reports idle
        tries = (kind == RUN_ACMD41_TMO) ? int'(cur_retry)
              : $urandom_range(0, (cur_retry > 16'd4) ? 3 : int'(cur_retry) - 1);
        for (int i = 0; i < tries; i++) begin
            add_frame();
            void'(add_reply(8'($urandom_range(0, 127)), poll_at == 2 && i == 0));
            add_frame();
            void'(add_reply(R1_IN_IDLE, 1'b0));
        end
        if (kind == RUN_ACMD41_TMO) return;
        add_frame();
        void'(add_reply(8'($urandom_range(0, 127)), poll_at == 2 && tries == 0));
        add_frame();
        r1 = ($urandom_range(0, 3) == 0) ? r1_other_than(R1_IN_IDLE) : R1_READY;
        void'(add_reply(r1, poll_at == 3));

        // CMD16 on the fast clock
        add_frame();
        r1 = (kind == RUN_CMD16_BAD) ? r1_other_than(R1_READY) : R1_READY;
        void'(add_reply(r1, poll_at == 4));
        if ($urandom_range(0, 3) == 0) push(FUNC_RXBYTE, rand_byte());
    endfunction

    task automatic pick_setting(input int idx);
        case (idx)
            1: write_config(8'd1, 16'd1, 8'd1, 1'b1);
            2: write_config(8'd255, 16'd65535, 8'd255, 1'b0);
            3: write_config(8'($urandom_range(1, 255)), 16'($urandom_range(1, 8)),
                            8'($urandom_range(1, 16)), 1'b0);
            default: write_config(
                ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                            : 8'($urandom_range(1, 255)),
                ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 8)),
                8'($urandom_range(1, 20)),
                $urandom_range(0, 3) == 0);
        endcase
    endtask

    initial begin
        int        goal;
        int        cut;
        bit        all_drained;
        run_kind_t kind;

        s_valid   <= 1'b0;
        s_func    <= FUNC_START;
        s_rx_byte <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_POLL_LIMIT;
        cfg_wdata <= 16'h0000;
        aresetn   <= 1'b0;
        cur_poll     = POLL_LIMIT_RST;
        cur_retry    = RETRY_LIMIT_RST;
        cur_wake     = WAKE_BYTES_RST;
        script_items = 0;
        n_settings   = 1;
        all_drained  = 1'b1;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: bytes while idle, start, wake bytes, restart mid-run
        push(FUNC_RXBYTE, 8'h00);
        push(FUNC_RXBYTE, 8'hFF);
        push(FUNC_START, 8'hFF);
        push(FUNC_RXBYTE, 8'h00);
        push(FUNC_RXBYTE, 8'hFF);
        push(FUNC_RXBYTE, 8'h5A);
        push(FUNC_START, 8'h00);
        push(FUNC_RXBYTE, 8'hA5);
        push(FUNC_START, 8'h7F);
        play_script();
        wait_idle(drained);
        all_drained &= drained;

        // Random runs, a new register setting for each stretch
        for (int idx = 0; script_items < ITEMS; idx++) begin
            if (idx > 0) begin
                wait_idle(drained);
                all_drained &= drained;
                pick_setting(idx);
            end
            goal = script_items + PHASE_ITEMS;
            while (script_items < goal && script_items < ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // loose noise: random functions and bytes
                    repeat ($urandom_range(1, 4))
                        push(1'($urandom_range(0, 1)), rand_byte());
                end else begin
                    kind = pick_kind();
                    build_run(kind);
                    if (kind == RUN_ABORT && card_q.size() > 1) begin
                        cut = $urandom_range(1, card_q.size() - 1);
                        while (card_q.size() > cut) void'(card_q.pop_back());
                    end
                    script_items += card_q.size();
                end
                play_script();
            end
        end

        wait_idle(drained);
        all_drained &= drained;
        if (!all_drained) $error("predicted results never arrived: %0d outstanding", pending);

        $display("Sent %0d input transfers over %0d register settings; checked %0d results.",
                 n_accepted, n_settings, checked);
        $display("Start-up runs ended: %0d ok, %0d with an error status.", runs_ok, runs_err);
        if (fail_count == 0 && all_drained) begin
            $display("sd_spi_init_sequencer regression: pass");
        end else begin
            $display("sd_spi_init_sequencer regression: fail");
        end
        $finish;
    end

endmodule
